// ===== hdl/bfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfcc_pkg
// shared types, constants and the crc-8 function of the frame checker
// ----------------------------------------------------------------------------
package bfcc_pkg;

  localparam int unsigned QBits = 24;
  localparam int unsigned RemW  = 84;
  localparam int unsigned UdW   = 64;

  localparam logic [7:0]  CrcPoly    = 8'h31;
  localparam logic [7:0]  CrcInit    = 8'hFF;
  localparam logic [20:0] PressMax   = 21'h1FFFFF;
  localparam logic [24:0] PressMid   = 25'd720000;
  localparam logic [22:0] PressScale = 23'd6720000;

  typedef enum logic [1:0] {
    OtpC0 = 2'd0,
    OtpC1 = 2'd1,
    OtpC2 = 2'd2,
    OtpC3 = 2'd3
  } otp_idx_e;

  typedef struct packed {
    logic        bad;
    logic [14:0] tsc;
  } side_t;

  typedef struct packed {
    side_t           side;
    logic            dz;
    logic            neg;
    logic            ovf;
    logic [RemW-1:0] rem;
    logic [UdW-1:0]  ud;
    logic [QBits-1:0] q;
  } div_t;

  function automatic logic [7:0] crc8_word(input logic [15:0] w);
    logic [7:0] c;
    c = CrcInit;
    for (int i = 15; i >= 0; i--) begin
      if (c[7] ^ w[i]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/bfcc_in_if.sv =====
// ----------------------------------------------------------------------------
// bfcc_in_if
// measurement frame channel: three words with their crc bytes
// ----------------------------------------------------------------------------
interface bfcc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] press_word_high;
  logic [7:0]  press_crc_high;
  logic [15:0] press_word_low;
  logic [7:0]  press_crc_low;
  logic [15:0] temp_word;
  logic [7:0]  temp_crc;

  modport source (
    output valid, press_word_high, press_crc_high, press_word_low,
           press_crc_low, temp_word, temp_crc,
    input  ready
  );
  modport sink (
    input  valid, press_word_high, press_crc_high, press_word_low,
           press_crc_low, temp_word, temp_crc,
    output ready
  );
endinterface

// ===== hdl/bfcc_out_if.sv =====
// ----------------------------------------------------------------------------
// bfcc_out_if
// result channel: status, compensated pressure and temperature
// ----------------------------------------------------------------------------
interface bfcc_out_if;
  logic               valid;
  logic               ready;
  logic               frame_status;
  logic [20:0]        pressure_sixteenths_pa;
  logic signed [14:0] temp_centi_deg;

  modport source (
    output valid, frame_status, pressure_sixteenths_pa, temp_centi_deg,
    input  ready
  );
  modport sink (
    input  valid, frame_status, pressure_sixteenths_pa, temp_centi_deg,
    output ready
  );
endinterface

// ===== hdl/baro_frame_check_and_compensate.sv =====
// ----------------------------------------------------------------------------
// baro_frame_check_and_compensate
// crc check of a sensor frame and three-point pressure compensation
// ----------------------------------------------------------------------------
// Takes one frame per clock while the output side does not stall and
// returns one result word per frame. The pressure quotient is formed by
// the 24-stage restoring divider, one quotient bit per stage, behind nine
// stages of crc check, squaring, calibration products and operand
// preparation. The whole pipe advances together and holds when the result
// register is full and not taken. Calibration constants are written through
// the plain write port; the user must write them only while no frame is in
// flight, which the block does not enforce. They reset to zero.
// ----------------------------------------------------------------------------
module baro_frame_check_and_compensate
  import bfcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  bfcc_in_if.sink     frm_in,
  bfcc_out_if.source  frm_out
);

  logic signed [15:0] otp0_q, otp1_q, otp2_q;
  logic [15:0]        otp3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      otp0_q <= '0;
      otp1_q <= '0;
      otp2_q <= '0;
      otp3_q <= '0;
    end else if (cfg_we_i) begin
      unique case (otp_idx_e'(cfg_idx_i))
        OtpC0: otp0_q <= cfg_wdata_i;
        OtpC1: otp1_q <= cfg_wdata_i;
        OtpC2: otp2_q <= cfg_wdata_i;
        OtpC3: otp3_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic             en;
  logic [8:0]       v_q;
  logic [QBits-1:0] vdiv_q;
  logic             vout_q;

  assign en           = !vout_q || frm_out.ready;
  assign frm_in.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      vdiv_q <= '0;
      vout_q <= 1'b0;
    end else if (en) begin
      v_q    <= {v_q[7:0], frm_in.valid};
      vdiv_q <= {vdiv_q[QBits-2:0], v_q[8]};
      vout_q <= vdiv_q[QBits-1];
    end
  end

  // stage 1: crc check, squaring, temperature scaling
  logic signed [15:0] t_in;
  logic signed [31:0] tt;
  logic [30:0]        tmul;
  side_t              side1_d;
  side_t              side1_q, side2_q, side3_q, side4_q;
  side_t              side5_q, side6_q, side7_q, side8_q;
  logic [23:0]        praw1_q, praw2_q, praw3_q;
  logic [30:0]        t2_q;

  assign t_in = signed'({~frm_in.temp_word[15], frm_in.temp_word[14:0]});
  assign tt   = 32'(t_in) * 32'(t_in);
  assign tmul = 31'(frm_in.temp_word) * 31'd17500 + 31'd32768;

  always_comb begin
    side1_d.bad = (crc8_word(frm_in.press_word_high) != frm_in.press_crc_high) ||
                  (crc8_word(frm_in.press_word_low) != frm_in.press_crc_low) ||
                  (crc8_word(frm_in.temp_word) != frm_in.temp_crc);
    side1_d.tsc = tmul[30:16];
  end

  // stage 2: quadratic products
  logic signed [47:0] kt0_q, kt1_q, kt2_q;
  logic signed [47:0] t2s;
  assign t2s = 48'(signed'({1'b0, t2_q}));

  // stage 3: lut points
  logic signed [47:0] qv0, qv1, qv2;
  logic signed [31:0] s1_q, s2_q, s3_q;
  assign qv0 = (kt0_q + 48'sd524288) >>> 20;
  assign qv1 = (kt1_q + 48'sd524288) >>> 20;
  assign qv2 = (kt2_q + 48'sd524288) >>> 20;

  // stage 4: differences
  logic signed [32:0] xs;
  logic signed [32:0] a_q, b_q, c_q, cmb_q;
  assign xs = 33'(signed'({1'b0, praw3_q, 4'd0}));

  // stage 5: products
  logic signed [65:0] ac_q, ab_q, bc_q, num_q;

  // stage 6: scaled terms and numerator magnitude
  logic signed [67:0] t12_q, t7_q, t5_q;
  logic signed [65:0] num_abs;
  logic [63:0]        un_q;
  logic               nneg6_q, nneg7_q;
  assign num_abs = num_q[65] ? -num_q : num_q;

  // stage 7: denominator and scaled numerator partial products
  logic signed [67:0] den_q;
  logic [54:0]        lo_q, hi_q;

  // stage 8: magnitudes and signs
  logic signed [67:0] den_abs;
  logic [86:0]        n87;
  logic               dz8_q, neg8_q;
  logic [UdW-1:0]     ud8_q;
  logic [RemW-1:0]    n2_q;
  assign den_abs = den_q[67] ? -den_q : den_q;
  assign n87     = (87'(hi_q) << 32) + 87'(lo_q);

  // stage 9: overflow check and divider set-up
  div_t div0_d;
  always_comb begin
    div0_d.side = side8_q;
    div0_d.dz   = dz8_q;
    div0_d.neg  = neg8_q;
    div0_d.ovf  = {4'd0, n2_q} >= {ud8_q, 24'd0};
    div0_d.rem  = n2_q;
    div0_d.ud   = ud8_q;
    div0_d.q    = '0;
  end

  div_t div_q [QBits+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      side1_q <= side1_d;
      praw1_q <= {frm_in.press_word_high, frm_in.press_word_low[15:8]};
      t2_q    <= tt[30:0];

      side2_q <= side1_q;
      praw2_q <= praw1_q;
      kt0_q   <= 48'(otp0_q) * t2s;
      kt1_q   <= 48'(otp1_q) * t2s;
      kt2_q   <= 48'(otp2_q) * t2s;

      side3_q <= side2_q;
      praw3_q <= praw2_q;
      s1_q    <= 32'sd58720256 + 32'(signed'(qv0[27:0]));
      s2_q    <= 32'(signed'({otp3_q, 15'd0})) + 32'(signed'(qv1[27:0]));
      s3_q    <= 32'sd192937984 + 32'(signed'(qv2[27:0]));

      side4_q <= side3_q;
      a_q     <= 33'(s1_q) - xs;
      b_q     <= 33'(s2_q) - xs;
      c_q     <= 33'(s3_q) - xs;
      cmb_q   <= 33'(s3_q) - 33'(s2_q);

      side5_q <= side4_q;
      ac_q    <= 66'(a_q) * 66'(c_q);
      ab_q    <= 66'(a_q) * 66'(b_q);
      bc_q    <= 66'(b_q) * 66'(c_q);
      num_q   <= 66'(a_q) * 66'(cmb_q);

      side6_q <= side5_q;
      t12_q   <= 68'(ac_q) * 68'sd12;
      t7_q    <= 68'(ab_q) * 68'sd7;
      t5_q    <= 68'(bc_q) * 68'sd5;
      un_q    <= num_abs[63:0];
      nneg6_q <= num_q[65];

      side7_q <= side6_q;
      den_q   <= t12_q - t7_q - t5_q;
      lo_q    <= 55'(un_q[31:0]) * 55'(PressScale);
      hi_q    <= 55'(un_q[63:32]) * 55'(PressScale);
      nneg7_q <= nneg6_q;

      side8_q <= side7_q;
      dz8_q   <= (den_q == '0);
      neg8_q  <= nneg7_q ^ den_q[67];
      ud8_q   <= den_abs[63:0];
      n2_q    <= {n87[82:0], 1'b0};

      div_q[0] <= div0_d;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < QBits; i++) begin : g_div
    localparam int unsigned K = QBits - 1 - i;
    logic [87:0] sh;
    logic [87:0] diff;
    logic        ge;
    div_t        nxt;

    assign sh   = 88'(div_q[i].ud) << K;
    assign ge   = 88'(div_q[i].rem) >= sh;
    assign diff = 88'(div_q[i].rem) - sh;

    always_comb begin
      nxt     = div_q[i];
      nxt.rem = ge ? diff[RemW-1:0] : div_q[i].rem;
      nxt.q   = {div_q[i].q[QBits-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        div_q[i+1] <= nxt;
      end
    end
  end

  // output stage: rounding, sign, saturation
  div_t               dq;
  logic [24:0]        qr;
  logic [24:0]        psum;
  logic signed [15:0] tcd;
  logic               status_d;
  logic [20:0]        press_d;
  logic               status_q;
  logic [20:0]        press_q;
  logic signed [14:0] temp_q;

  assign dq   = div_q[QBits];
  assign qr   = (25'(dq.q) + 25'd1) >> 1;
  assign psum = PressMid + qr;
  assign tcd  = signed'({1'b0, dq.side.tsc}) - 16'sd4500;

  always_comb begin
    status_d = 1'b0;
    if (dq.side.bad) begin
      status_d = 1'b1;
      press_d  = '0;
    end else if (dq.dz) begin
      press_d = PressMax;
    end else if (dq.ovf) begin
      press_d = dq.neg ? '0 : PressMax;
    end else if (dq.neg) begin
      press_d = (qr > PressMid) ? '0 : 21'(PressMid - qr);
    end else begin
      press_d = (psum > 25'(PressMax)) ? PressMax : psum[20:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= status_d;
      press_q  <= press_d;
      temp_q   <= dq.side.bad ? '0 : tcd[14:0];
    end
  end

  assign frm_out.valid                  = vout_q;
  assign frm_out.frame_status           = status_q;
  assign frm_out.pressure_sixteenths_pa = press_q;
  assign frm_out.temp_centi_deg         = temp_q;

endmodule
